>>> src/smr_pkg.sv
// Shared types, codes and key routing tables for the split matrix receiver.
// No dependencies; every other source file except smr_if.sv imports this package.
`default_nettype none

package smr_pkg;

    localparam int unsigned STORE_LEN = 14;
    localparam int unsigned ROW_COUNT = 6;
    localparam int unsigned KEY_COUNT = 35;
    localparam int unsigned IDX_W     = 4;

    localparam logic [7:0]       FRAME_END   = 8'hE0;
    localparam logic [7:0]       IDLE_STATUS = 8'd100;
    localparam logic [7:0]       LIMIT_RESET = 8'd3;
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(STORE_LEN);

    typedef enum logic [1:0] {
        OP_LEFT  = 2'd0,
        OP_RIGHT = 2'd1,
        OP_TICK  = 2'd2,
        OP_POLL  = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    typedef struct packed {
        logic load_left;
        logic load_right;
        logic tick;
        logic start_poll;
        logic advance;
    } smr_cmd_t;

    typedef struct packed {
        logic at_last;
    } smr_sts_t;

    typedef logic [5:0] key_map_t [KEY_COUNT];

    // Destination of each key bit: row * 8 + bit within the row byte.
    localparam key_map_t LEFT_MAP = '{
        6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd38,
        6'd45, 6'd46
    };

    localparam key_map_t RIGHT_MAP = '{
        6'd6,  6'd5,  6'd4,  6'd3,  6'd2,  6'd1,  6'd0,
        6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,
        6'd22, 6'd21, 6'd20, 6'd19, 6'd18, 6'd17,
        6'd30, 6'd29, 6'd28, 6'd27, 6'd26, 6'd25, 6'd24,
        6'd38, 6'd37, 6'd36, 6'd35, 6'd33, 6'd32,
        6'd41, 6'd40
    };

    // Scatter the key bits of one half into its six row bytes.
    function automatic logic [8*ROW_COUNT-1:0] route_keys(
        input logic [KEY_COUNT-1:0] keys,
        input logic                 right_side
    );
        logic [8*ROW_COUNT-1:0] rows;
        logic [5:0]             dst;
        rows = '0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            dst = right_side ? RIGHT_MAP[k] : LEFT_MAP[k];
            if (keys[k])
            begin
                rows[dst] = 1'b1;
            end
        end
        return rows;
    endfunction

endpackage

`default_nettype wire

>>> src/smr_if.sv
// Handshake channel interfaces: packet/command items in, report bytes out.
// Depends on nothing; payload widths are fixed by the item format.
`default_nettype none

interface smr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] payload_byte0;
    logic [7:0] payload_byte1;
    logic [7:0] payload_byte2;
    logic [7:0] payload_byte3;
    logic [7:0] payload_byte4;
    logic [7:0] payload_status;

    modport source (
        output valid, operation, payload_byte0, payload_byte1, payload_byte2,
               payload_byte3, payload_byte4, payload_status,
        input  ready
    );
    modport sink (
        input  valid, operation, payload_byte0, payload_byte1, payload_byte2,
               payload_byte3, payload_byte4, payload_status,
        output ready
    );
endinterface

interface smr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte;
    logic       last_byte;

    modport source (
        output valid, report_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, report_byte, last_byte,
        output ready
    );
endinterface

`default_nettype wire

>>> src/smr_ctrl.sv
// Control state machine: decodes accepted items and sequences a report poll.
// Depends on smr_pkg for op codes, states and command/status structs.
`default_nettype none

module smr_ctrl
    import smr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic [1:0] in_op,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output smr_cmd_t      cmd,
    input  wire smr_sts_t sts
);

    state_t state_reg;
    state_t state_next;
    op_t    op;

    assign op = op_t'(in_op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (op)
                        OP_LEFT:  cmd.load_left  = 1'b1;
                        OP_RIGHT: cmd.load_right = 1'b1;
                        OP_TICK:  cmd.tick       = 1'b1;
                        OP_POLL:
                        begin
                            cmd.start_poll = 1'b1;
                            state_next     = ST_STREAM;
                        end
                        default: ;
                    endcase
                end
            end
            ST_STREAM:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.advance = 1'b1;
                    if (sts.at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> src/smr_datapath.sv
// Datapath: report store, idle counters, limit register and frame byte select.
// Depends on smr_pkg for key routing, constants and command/status structs.
`default_nettype none

module smr_datapath
    import smr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic [7:0] payload_byte0,
    input  wire logic [7:0] payload_byte1,
    input  wire logic [7:0] payload_byte2,
    input  wire logic [7:0] payload_byte3,
    input  wire logic [7:0] payload_byte4,
    input  wire logic [7:0] payload_status,
    input  wire smr_cmd_t   cmd,
    output smr_sts_t        sts,
    output logic [7:0]      report_byte,
    output logic            last_byte
);

    logic [7:0]       store_reg [STORE_LEN];
    logic [7:0]       limit_reg;
    logic [7:0]       left_count_reg;
    logic [7:0]       right_count_reg;
    logic [IDX_W-1:0] idx_reg;

    logic [KEY_COUNT-1:0]   keys;
    logic [8*ROW_COUNT-1:0] rows;
    logic [7:0]             left_sum;
    logic [7:0]             right_sum;
    logic                   left_inc;
    logic                   right_inc;
    logic                   left_expire;
    logic                   right_expire;

    assign keys = {payload_byte4[2:0], payload_byte3, payload_byte2,
                   payload_byte1, payload_byte0};
    assign rows = route_keys(keys, cmd.load_right);

    assign left_inc     = left_count_reg < limit_reg;
    assign right_inc    = right_count_reg < limit_reg;
    assign left_sum     = left_count_reg + 8'd1;
    assign right_sum    = right_count_reg + 8'd1;
    assign left_expire  = left_inc && (left_sum == limit_reg);
    assign right_expire = right_inc && (right_sum == limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_LEN; i++)
            begin
                store_reg[i] <= '0;
            end
            left_count_reg  <= '0;
            right_count_reg <= '0;
        end
        else
        begin
            if (cmd.load_left || cmd.load_right)
            begin
                for (int k = 0; k < ROW_COUNT; k++)
                begin
                    store_reg[2*k + int'(cmd.load_right)] <= rows[8*k +: 8];
                end
                store_reg[2*ROW_COUNT + int'(cmd.load_right)] <= payload_status;
                if (cmd.load_left)
                begin
                    left_count_reg <= '0;
                end
                else
                begin
                    right_count_reg <= '0;
                end
            end
            if (cmd.tick)
            begin
                if (left_inc)
                begin
                    left_count_reg <= left_sum;
                end
                if (right_inc)
                begin
                    right_count_reg <= right_sum;
                end
                if (left_expire)
                begin
                    for (int k = 0; k < ROW_COUNT; k++)
                    begin
                        store_reg[2*k] <= '0;
                    end
                    store_reg[2*ROW_COUNT] <= IDLE_STATUS;
                end
                if (right_expire)
                begin
                    for (int k = 0; k < ROW_COUNT; k++)
                    begin
                        store_reg[2*k + 1] <= '0;
                    end
                    store_reg[2*ROW_COUNT + 1] <= IDLE_STATUS;
                end
            end
        end
    end

    // Frame position counter: store bytes first, closing byte at LAST_IDX.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.start_poll)
        begin
            idx_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        last_byte   = (idx_reg == LAST_IDX);
        sts.at_last = last_byte;
        if (idx_reg < LAST_IDX)
        begin
            report_byte = store_reg[idx_reg];
        end
        else
        begin
            report_byte = FRAME_END;
        end
    end

endmodule

`default_nettype wire

>>> src/split_matrix_merge_and_report.sv
// Top level of the split keyboard matrix receiver: controller plus datapath.
// Depends on smr_pkg, smr_if.sv, smr_ctrl.sv and smr_datapath.sv.
//
//  channel     dir  handshake      payload
//  ---------   ---  -------------  ------------------------------------------
//  packet_in   in   valid/ready    operation, payload_byte0..4, payload_status
//  report_out  out  valid/ready    report_byte, last_byte
//  cfg         in   cfg_wr_en      cfg_wr_data -> idle_tick_limit
//
//  Packet and tick items are accepted while idle; the block is ready again the
//  next cycle. A poll item streams 15 bytes, one per cycle in which
//  report_out.ready is high, paced by the frame position counter; packet_in
//  is held off until the closing 0xE0 byte is taken.
//  Reset (rst_n low, asynchronous) clears the store and both idle counters
//  and sets the tick limit to 3; no clearing pass is needed.
//  A stall on report_out holds the current byte and the frame position.
`default_nettype none

module split_matrix_merge_and_report
    import smr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    smr_in_if.sink          packet_in,
    smr_out_if.source       report_out
);

    smr_cmd_t cmd;
    smr_sts_t sts;

    // Decode accepted items and pace the report frame.
    smr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (packet_in.valid),
        .in_op     (packet_in.operation),
        .in_ready  (packet_in.ready),
        .out_valid (report_out.valid),
        .out_ready (report_out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Hold the store and counters, route key bits, select frame bytes.
    smr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .payload_byte0  (packet_in.payload_byte0),
        .payload_byte1  (packet_in.payload_byte1),
        .payload_byte2  (packet_in.payload_byte2),
        .payload_byte3  (packet_in.payload_byte3),
        .payload_byte4  (packet_in.payload_byte4),
        .payload_status (packet_in.payload_status),
        .cmd            (cmd),
        .sts            (sts),
        .report_byte    (report_out.report_byte),
        .last_byte      (report_out.last_byte)
    );

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for split_matrix_merge_and_report: it merges the key packets of both
// halves, ages them with ticks, and checks every polled report byte against its own predictor.
// Depends on smr_pkg (op_t) and the smr_in_if / smr_out_if channel interfaces.
`timescale 1ns / 1ps

module testbench;
    import smr_pkg::op_t;
    import smr_pkg::OP_LEFT;
    import smr_pkg::OP_RIGHT;
    import smr_pkg::OP_TICK;
    import smr_pkg::OP_POLL;

    localparam int         ROWS        = 6;
    localparam int         KEYS        = 35;
    localparam logic [7:0] END_OF_FRAME = 8'hE0;
    localparam logic [7:0] SILENT_MARK  = 8'd100;
    localparam int         HOLD_CYCLES  = 120;

    // Destination of each key bit, as row * 8 + bit within the row byte.
    localparam logic [5:0] LEFT_KEY_DEST [KEYS] = '{
        6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
        6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd38,
        6'd45, 6'd46
    };
    localparam logic [5:0] RIGHT_KEY_DEST [KEYS] = '{
        6'd6,  6'd5,  6'd4,  6'd3,  6'd2,  6'd1,  6'd0,
        6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,
        6'd22, 6'd21, 6'd20, 6'd19, 6'd18, 6'd17,
        6'd30, 6'd29, 6'd28, 6'd27, 6'd26, 6'd25, 6'd24,
        6'd38, 6'd37, 6'd36, 6'd35, 6'd33, 6'd32,
        6'd41, 6'd40
    };

    // One item on the packet link: payload bytes 0..4 packed as keys[39:0].
    typedef struct packed {
        op_t         op;
        logic [39:0] keys;
        logic [7:0]  status;
    } link_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    smr_in_if  packet_if ();
    smr_out_if report_if ();

    split_matrix_merge_and_report u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .packet_in  (packet_if),
        .report_out (report_if)
    );

    // Predictor state: the merged store, the two silence counters and the tick limit.
    logic [7:0] store_model [14];
    logic [7:0] silent_ticks [2];
    logic [7:0] tick_limit_model;

    link_item_t  pending_items [$];
    link_item_t  offered_item;
    frame_byte_t expected_frame [$];

    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    logic hold_trigger = 1'b0;
    int   hold_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Apply one accepted item to the predictor; a poll queues the whole frame.
    function automatic void merge_and_predict(input link_item_t it);
        logic [7:0] rows [ROWS];
        logic [5:0] dst;
        int         side;
        case (it.op)
            OP_LEFT, OP_RIGHT:
            begin
                side = (it.op == OP_RIGHT) ? 1 : 0;
                for (int r = 0; r < ROWS; r++)
                begin
                    rows[r] = 8'h00;
                end
                // bits 35..39 of the key field never reach a row
                for (int k = 0; k < KEYS; k++)
                begin
                    dst = side ? RIGHT_KEY_DEST[k] : LEFT_KEY_DEST[k];
                    if (it.keys[k])
                    begin
                        rows[dst[5:3]][dst[2:0]] = 1'b1;
                    end
                end
                for (int r = 0; r < ROWS; r++)
                begin
                    store_model[2*r + side] = rows[r];
                end
                store_model[12 + side] = it.status;
                silent_ticks[side] = 8'd0;
            end
            OP_TICK:
            begin
                // a counter at or past the limit is frozen, so the wipe happens once
                for (int s = 0; s < 2; s++)
                begin
                    if (silent_ticks[s] < tick_limit_model)
                    begin
                        silent_ticks[s] = silent_ticks[s] + 8'd1;
                        if (silent_ticks[s] == tick_limit_model)
                        begin
                            for (int r = 0; r < ROWS; r++)
                            begin
                                store_model[2*r + s] = 8'h00;
                            end
                            store_model[12 + s] = SILENT_MARK;
                        end
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < 14; i++)
                begin
                    expected_frame.push_back('{data: store_model[i], last: 1'b0});
                end
                expected_frame.push_back('{data: END_OF_FRAME, last: 1'b1});
            end
        endcase
    endfunction

    // Driver: predict on acceptance, then offer the next pending item or idle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            packet_if.valid <= 1'b0;
        end
        else
        begin
            if (packet_if.valid && packet_if.ready)
            begin
                merge_and_predict(offered_item);
            end
            if (!packet_if.valid || packet_if.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    offered_item = pending_items.pop_front();
                    packet_if.valid          <= 1'b1;
                    packet_if.operation      <= offered_item.op;
                    packet_if.payload_byte0  <= offered_item.keys[7:0];
                    packet_if.payload_byte1  <= offered_item.keys[15:8];
                    packet_if.payload_byte2  <= offered_item.keys[23:16];
                    packet_if.payload_byte3  <= offered_item.keys[31:24];
                    packet_if.payload_byte4  <= offered_item.keys[39:32];
                    packet_if.payload_status <= offered_item.status;
                end
                else
                begin
                    packet_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_trigger)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each accepted report byte with the oldest expected one.
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (!rst_n)
        begin
            report_if.ready <= 1'b0;
        end
        else
        begin
            if (report_if.valid && report_if.ready)
            begin
                if (expected_frame.size() == 0)
                begin
                    flag_mismatch($sformatf("report byte %h with nothing expected",
                                            report_if.report_byte));
                end
                else
                begin
                    want = expected_frame.pop_front();
                    if (report_if.report_byte !== want.data)
                    begin
                        flag_mismatch($sformatf("report_byte %h, want %h",
                                                report_if.report_byte, want.data));
                    end
                    if (report_if.last_byte !== want.last)
                    begin
                        flag_mismatch($sformatf("last_byte %b, want %b on byte %h",
                                                report_if.last_byte, want.last, want.data));
                    end
                end
            end
            report_if.ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic void queue_item(input op_t op, input logic [39:0] keys,
                                       input logic [7:0] status);
        pending_items.push_back('{op: op, keys: keys, status: status});
    endfunction

    // Sample at the falling edge so the driver's pops and pushes have settled.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || packet_if.valid || expected_frame.size() != 0);
        // packets and ticks leave no result behind; give the last one time to land
        repeat (4) @(negedge clk);
    endtask

    task automatic write_idle_limit(input logic [7:0] limit);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tick_limit_model = limit;
    endtask

    // Random phase: mostly packets and ticks with polls sprinkled in.
    task automatic run_random(input int count, input int src_pct, input int snk_pct,
                              input int tick_pct, input bit long_hold);
        link_item_t it;
        int         pick;
        @(negedge clk);
        sender_idle_pct    = src_pct;
        receiver_stall_pct = snk_pct;
        // lead with a poll so the held-off frame backs up into the packet link
        if (long_hold)
        begin
            queue_item(OP_POLL, 40'h0, 8'h00);
        end
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                it.op = OP_POLL;
            end
            else if (pick < 12 + tick_pct)
            begin
                it.op = OP_TICK;
            end
            else
            begin
                it.op = pick[0] ? OP_RIGHT : OP_LEFT;
            end
            case ($urandom_range(7))
                0:       it.keys = 40'h0;
                1:       it.keys = '1;
                default: it.keys = 40'({$urandom, $urandom});
            endcase
            case ($urandom_range(5))
                0:       it.status = 8'h00;
                1:       it.status = 8'hFF;
                2:       it.status = SILENT_MARK;
                default: it.status = 8'($urandom_range(255));
            endcase
            pending_items.push_back(it);
        end
        if (long_hold)
        begin
            hold_trigger = 1'b1;
            @(negedge clk);
            hold_trigger = 1'b0;
        end
        wait_until_drained();
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        cfg_wr_en                = 1'b0;
        cfg_wr_data              = 8'h00;
        packet_if.valid          = 1'b0;
        packet_if.operation      = OP_LEFT;
        packet_if.payload_byte0  = 8'h00;
        packet_if.payload_byte1  = 8'h00;
        packet_if.payload_byte2  = 8'h00;
        packet_if.payload_byte3  = 8'h00;
        packet_if.payload_byte4  = 8'h00;
        packet_if.payload_status = 8'h00;
        report_if.ready          = 1'b0;
        for (int i = 0; i < 14; i++)
        begin
            store_model[i] = 8'h00;
        end
        silent_ticks[0]  = 8'd0;
        silent_ticks[1]  = 8'd0;
        tick_limit_model = 8'd3;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset limit of 3.
        @(negedge clk);
        queue_item(OP_POLL,  40'h0,            8'h00);  // store cleared by reset
        queue_item(OP_LEFT,  40'hFF_FFFF_FFFF, 8'hFF);  // every key, unused bits set
        queue_item(OP_RIGHT, 40'hFF_FFFF_FFFF, 8'h00);
        queue_item(OP_POLL,  40'h0,            8'h00);
        queue_item(OP_LEFT,  40'h00_0000_0000, 8'h5A);  // no keys overwrites the rows
        queue_item(OP_RIGHT, 40'h05_AA55_AA55, 8'hA5);
        queue_item(OP_LEFT,  40'h02_55AA_55AA, 8'h7E);
        queue_item(OP_POLL,  40'h0,            8'h00);
        queue_item(OP_TICK,  40'h0,            8'h00);
        queue_item(OP_TICK,  40'h0,            8'h00);
        queue_item(OP_LEFT,  40'h01_8421_0842, 8'h33);  // left counter restarts
        queue_item(OP_TICK,  40'h0,            8'h00);  // right goes silent
        queue_item(OP_POLL,  40'h0,            8'h00);
        queue_item(OP_TICK,  40'h0,            8'h00);
        queue_item(OP_TICK,  40'h0,            8'h00);  // left goes silent
        queue_item(OP_TICK,  40'h0,            8'h00);  // both frozen, no second wipe
        queue_item(OP_POLL,  40'h0,            8'h00);
        queue_item(OP_RIGHT, 40'h04_1248_8124, 8'hC3);  // frozen right counter released
        queue_item(OP_POLL,  40'h0,            8'h00);
        wait_until_drained();

        // Limit 1 with the left counter already frozen past it.
        write_idle_limit(8'd1);
        run_random(45, 0, 0, 30, 1'b0);

        // Raise the limit: held counters resume from where they stopped.
        write_idle_limit(8'd7);
        run_random(45, 58, 0, 40, 1'b0);

        // Lower below the counters, with a long output hold-off up front.
        write_idle_limit(8'd2);
        run_random(45, 0, 58, 30, 1'b1);

        // High limit: a long silent run to reach the wipe at 30.
        write_idle_limit(8'd30);
        run_random(30, 22, 22, 30, 1'b0);
        @(negedge clk);
        repeat (31) queue_item(OP_TICK, 40'h0, 8'h00);
        queue_item(OP_POLL, 40'h0, 8'h00);
        wait_until_drained();

        write_idle_limit(8'd4);
        run_random(45, 22, 22, 35, 1'b0);

        write_idle_limit(8'd10);
        run_random(25, 0, 0, 55, 1'b0);

        wait_until_drained();
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
src/smr_pkg.sv
src/smr_if.sv
src/smr_ctrl.sv
src/smr_datapath.sv
src/split_matrix_merge_and_report.sv
test/testbench.sv
